### rtl/core/mbwl_pkg.sv
// Package for the Modbus request whitelist filter.
// Holds sizes, item kind codes, the rule word layout and address helpers.
// No dependencies; every other file of the block imports it.
`default_nettype none

package mbwl_pkg;

   // Number of rule lists and rules per list.
   localparam int NUM_LISTS = 2;
   localparam int MAX_RULES = 16;

   // Derived widths.
   localparam int LIST_W     = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
   localparam int RULE_IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
   localparam int CNT_W      = $clog2(MAX_RULES + 1);
   localparam int RAM_DEPTH  = NUM_LISTS * MAX_RULES;
   localparam int ADDR_W     = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

   // Item kind codes.
   localparam logic [1:0] KIND_CHECK  = 2'd0;
   localparam logic [1:0] KIND_APPEND = 2'd1;
   localparam logic [1:0] KIND_CLEAR  = 2'd2;

   // One stored rule.
   typedef struct packed {
      logic [7:0]  fc;
      logic [15:0] first;
      logic [15:0] count;
   } rule_type;

   // Result of comparing one rule against the pending request.
   typedef struct packed {
      logic fc_hit;
      logic hit;
   } match_type;

   // True when a list number names an existing list.
   function automatic logic list_ok(input logic sel);
      list_ok = ({31'd0, sel} < 32'(NUM_LISTS));
   endfunction

   // Rule memory address of entry idx in list sel.
   function automatic logic [ADDR_W-1:0] rule_addr(input logic                  sel,
                                                   input logic [RULE_IDX_W-1:0] idx);
      rule_addr = ADDR_W'(32'({31'd0, sel}) * 32'(MAX_RULES) + 32'(idx));
   endfunction

endpackage

`default_nettype wire

### rtl/core/modbus_request_whitelist_filter_core.sv
// Top level of the Modbus request whitelist filter.
// Sequencer, list counts and result register; uses mbwl_pkg, mbwl_rule_ram, mbwl_match_unit.
`default_nettype none

// The filter keeps NUM_LISTS whitelists of up to MAX_RULES rules each, every rule being a
// function code, a start register and a register count. Each input word either checks a
// request against the list chosen by the active_list register (written through csr_wr_en
// and csr_wr_data; the user must write it only while the block is idle, which the block
// does not enforce), appends a rule to a list, or clears a list, and each input word
// produces exactly one output word. A check walks the active list in append order through
// a single compare unit, reading one rule per cycle from the rule memory, and stops at the
// first rule that allows the request; a check of an empty list skips the scan. A finished
// word whose predecessor still waits for rsp_ready stays in the done state until that
// output word is taken. The output word sits in its own register, so a new input word is
// accepted while an earlier result still waits for rsp_ready. An append to a full list
// changes nothing and answers status 1. A rule with count 0 allows its function code at
// any register; otherwise both the request's first and last register must lie inside the
// rule's range, with last registers computed modulo 2^16. The rule memory is not cleared
// at reset; only entries below a list's count are ever used by a check.

module modbus_request_whitelist_filter_core
   import mbwl_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_kind,
   input  wire logic        req_list_select,
   input  wire logic [7:0]  req_function_code,
   input  wire logic [15:0] req_start_register,
   input  wire logic [15:0] req_register_count,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_verdict,
   output logic             rsp_status,

   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data
);

   // Sequencer states.
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic             active_ff;

   logic [CNT_W-1:0] counts_ff [NUM_LISTS];
   logic [CNT_W-1:0] counts_in [NUM_LISTS];

   // Request held for the scan.
   logic [7:0]       req_fc_ff, req_fc_in;
   logic [15:0]      req_first_ff, req_first_in;
   logic [15:0]      req_last_ff, req_last_in;
   logic             scan_list_ff, scan_list_in;
   logic [CNT_W-1:0] scan_cnt_ff, scan_cnt_in;

   // Read pipeline of the scan.
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic             rd_pend_ff, rd_pend_in;
   logic             rd_last_ff, rd_last_in;

   // Result of the current word, then the output register.
   logic             res_verdict_ff, res_verdict_in;
   logic             res_status_ff, res_status_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_verdict_ff, rsp_verdict_in;
   logic             rsp_status_ff, rsp_status_in;

   logic             req_accept;
   logic             issue_en;
   logic             sel_ok;
   logic             act_ok;
   logic [CNT_W-1:0] sel_count;
   logic [CNT_W-1:0] act_count;
   logic             ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [ADDR_W-1:0] ram_rd_addr;
   rule_type         ram_wr_data;
   rule_type         ram_rd_data;
   match_type        match;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;

   assign sel_ok    = list_ok(req_list_select);
   assign act_ok    = list_ok(active_ff);
   assign sel_count = sel_ok ? counts_ff[LIST_W'(req_list_select)] : '0;
   assign act_count = act_ok ? counts_ff[LIST_W'(active_ff)] : '0;

   // Appends write the rule memory in the accept cycle.
   assign ram_wr_en   = req_accept && (req_kind == KIND_APPEND) && sel_ok &&
                        ({{(32-CNT_W){1'b0}}, sel_count} < 32'(MAX_RULES));
   assign ram_wr_addr = rule_addr(req_list_select, sel_count[RULE_IDX_W-1:0]);
   assign ram_wr_data = '{fc: req_function_code, first: req_start_register,
                          count: req_register_count};

   assign issue_en    = (state_ff == ST_SCAN) && (issue_ff < scan_cnt_ff);
   assign ram_rd_addr = rule_addr(scan_list_ff, issue_ff[RULE_IDX_W-1:0]);

   mbwl_rule_ram u_rule_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   mbwl_match_unit u_match_unit (
      .rule      (ram_rd_data),
      .req_fc    (req_fc_ff),
      .req_first (req_first_ff),
      .req_last  (req_last_ff),
      .result    (match)
   );

   always_comb begin
      state_in       = state_ff;
      counts_in      = counts_ff;
      req_fc_in      = req_fc_ff;
      req_first_in   = req_first_ff;
      req_last_in    = req_last_ff;
      scan_list_in   = scan_list_ff;
      scan_cnt_in    = scan_cnt_ff;
      issue_in       = issue_ff;
      rd_pend_in     = 1'b0;
      rd_last_in     = 1'b0;
      res_verdict_in = res_verdict_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_status_in  = rsp_status_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               res_verdict_in = 1'b0;
               res_status_in  = 1'b0;
               state_in       = ST_DONE;
               case (req_kind)
                  KIND_CHECK: begin
                     req_fc_in    = req_function_code;
                     req_first_in = req_start_register;
                     req_last_in  = req_start_register + req_register_count - 16'd1;
                     scan_list_in = active_ff;
                     scan_cnt_in  = act_count;
                     issue_in     = '0;
                     if (act_count != '0) begin
                        state_in = ST_SCAN;
                     end
                  end
                  KIND_APPEND: begin
                     if (sel_ok) begin
                        if (ram_wr_en) begin
                           counts_in[LIST_W'(req_list_select)] = sel_count + CNT_W'(1);
                        end else begin
                           res_status_in = 1'b1;
                        end
                     end
                  end
                  KIND_CLEAR: begin
                     if (sel_ok) begin
                        counts_in[LIST_W'(req_list_select)] = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (issue_en) begin
               issue_in   = issue_ff + CNT_W'(1);
               rd_pend_in = 1'b1;
               rd_last_in = ((issue_ff + CNT_W'(1)) == scan_cnt_ff);
            end
            if (rd_pend_ff && match.hit) begin
               res_verdict_in = 1'b1;
               rd_pend_in     = 1'b0;
               state_in       = ST_DONE;
            end else if (rd_pend_ff && rd_last_ff) begin
               res_verdict_in = 1'b0;
               rd_pend_in     = 1'b0;
               state_in       = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_verdict_in = res_verdict_ff;
               rsp_status_in  = res_status_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= 1'b0;
         rd_pend_ff   <= 1'b0;
         rd_last_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_LISTS; i++) begin
            counts_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= rd_pend_in;
         rd_last_ff   <= rd_last_in;
         rsp_valid_ff <= rsp_valid_in;
         counts_ff    <= counts_in;
         if (csr_wr_en) begin
            active_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      req_fc_ff      <= req_fc_in;
      req_first_ff   <= req_first_in;
      req_last_ff    <= req_last_in;
      scan_list_ff   <= scan_list_in;
      scan_cnt_ff    <= scan_cnt_in;
      issue_ff       <= issue_in;
      res_verdict_ff <= res_verdict_in;
      res_status_ff  <= res_status_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = rsp_verdict_ff;
   assign rsp_status  = rsp_status_ff;

`ifndef SYNTHESIS
   // An accepted word always takes the block out of the idle state.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_ready)
      else $error("input accepted again right after an accept");

   // A scan only runs over a non-empty list and never issues past its end.
   a_scan_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> ((scan_cnt_ff != '0) && (issue_ff <= scan_cnt_ff)))
      else $error("scan outside list bounds");

   // Rule data is only consumed while scanning.
   a_read_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> (state_ff == ST_SCAN))
      else $error("rule read pending outside scan");

   // An allowed check never carries the list-full flag.
   a_verdict_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_verdict_ff && rsp_status_ff))
      else $error("verdict and status both set");
`endif

endmodule

`default_nettype wire

### rtl/core/mbwl_rule_ram.sv
// Rule storage for the Modbus request whitelist filter.
// One write port and one registered read port; depends on mbwl_pkg.
`default_nettype none

module mbwl_rule_ram
   import mbwl_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire rule_type          wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output rule_type               rd_data
);

   rule_type mem [RAM_DEPTH];
   rule_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/core/mbwl_match_unit.sv
// Shared rule compare unit for the Modbus request whitelist filter.
// Compares one stored rule with the request; depends on mbwl_pkg.
`default_nettype none

module mbwl_match_unit
   import mbwl_pkg::*;
(
   input  wire rule_type    rule,
   input  wire logic [7:0]  req_fc,
   input  wire logic [15:0] req_first,
   input  wire logic [15:0] req_last,
   output match_type        result
);

   logic [15:0] rule_last;
   logic        in_range;

   // The last register wraps at 16 bits.
   assign rule_last = rule.first + rule.count - 16'd1;
   assign in_range  = (req_first >= rule.first) && (req_last <= rule_last);

   assign result.fc_hit = (rule.fc == req_fc);
   assign result.hit    = result.fc_hit && ((rule.count == 16'd0) || in_range);

endmodule

`default_nettype wire

### tb/modbus_request_whitelist_filter_core_test.sv
// Self-checking testbench for modbus_request_whitelist_filter_core: drives request words,
// predicts every response word and compares them as they leave the block.
// Depends on mbwl_pkg and the filter core RTL only.
`timescale 1ns / 1ps

module modbus_request_whitelist_filter_core_test
   import mbwl_pkg::*;
();

   // Kind code the block does not use; it must answer with an all-zero word.
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   // The run is cut off here.
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_PHASES = 12;
   localparam int WORDS_PER_PHASE = 140;
   // Longest a check may keep the block busy, plus margin, for the settle at the end.
   localparam int SETTLE_CYCLES = MAX_RULES + 8;

   typedef struct {
      bit verdict;
      bit status;
   } response_type;

   // Keeps its own copy of the rule lists and the active list, works out the response
   // word for every request word the block takes, and checks responses in order.
   class whitelist_scoreboard;
      rule_type     rules [NUM_LISTS][MAX_RULES];
      int unsigned  rule_total [NUM_LISTS];
      logic         active;
      response_type expected_responses [$];
      int           errors;

      function new();
         for (int i = 0; i < NUM_LISTS; i++) begin
            rule_total[i] = 0;
         end
         active = 1'b0;
         errors = 0;
      endfunction

      task report(input string msg);
         if (errors < 40) begin
            $display("ERROR at %0t: %s", $realtime, msg);
         end
         errors++;
      endtask

      function int pending();
         return expected_responses.size();
      endfunction

      function void set_active(input logic value);
         active = value;
      endfunction

      // Rules are tried in append order; the first one that covers the request allows it.
      function bit list_permits(input logic sel, input logic [7:0] fc,
                                input logic [15:0] first, input logic [15:0] count);
         logic [15:0] req_last;
         logic [15:0] rule_last;
         rule_type    r;
         req_last = first + count - 16'd1;
         if (int'(sel) >= NUM_LISTS) begin
            return 1'b0;
         end
         for (int i = 0; i < int'(rule_total[sel]); i++) begin
            r = rules[sel][i];
            if (r.fc == fc) begin
               if (r.count == 16'd0) begin
                  return 1'b1;
               end
               rule_last = r.first + r.count - 16'd1;
               if (first >= r.first && req_last <= rule_last) begin
                  return 1'b1;
               end
            end
         end
         return 1'b0;
      endfunction

      function void note_request(input logic [1:0] kind, input logic sel, input logic [7:0] fc,
                                 input logic [15:0] first, input logic [15:0] count);
         response_type rsp;
         rsp.verdict = 1'b0;
         rsp.status  = 1'b0;
         case (kind)
            KIND_CHECK: begin
               rsp.verdict = list_permits(active, fc, first, count);
            end
            KIND_APPEND: begin
               if (int'(sel) < NUM_LISTS) begin
                  if (rule_total[sel] >= MAX_RULES) begin
                     rsp.status = 1'b1;
                  end else begin
                     rules[sel][rule_total[sel]].fc    = fc;
                     rules[sel][rule_total[sel]].first = first;
                     rules[sel][rule_total[sel]].count = count;
                     rule_total[sel]++;
                  end
               end
            end
            KIND_CLEAR: begin
               if (int'(sel) < NUM_LISTS) begin
                  rule_total[sel] = 0;
               end
            end
            default: begin
            end
         endcase
         expected_responses.push_back(rsp);
      endfunction

      // Fields are taken four-state so that an unknown output bit shows up as a mismatch.
      task check_response(input logic verdict, input logic status);
         response_type want;
         if (expected_responses.size() == 0) begin
            report("response word arrived with nothing pending");
         end else begin
            want = expected_responses.pop_front();
            if (verdict !== want.verdict) begin
               report($sformatf("verdict got %0b want %0b", verdict, want.verdict));
            end
            if (status !== want.status) begin
               report($sformatf("status got %0b want %0b", status, want.status));
            end
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_kind = KIND_CHECK;
   logic        req_list_select = 1'b0;
   logic [7:0]  req_function_code = 8'd0;
   logic [15:0] req_start_register = 16'd0;
   logic [15:0] req_register_count = 16'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_verdict;
   logic        rsp_status;
   logic        csr_wr_en = 1'b0;
   logic        csr_wr_data = 1'b0;

   whitelist_scoreboard sb;

   // Percent of cycles in which the sender or the receiver sits idle.
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   // A long receiver hold-off is requested by bumping hold_seq; the receiver process
   // notices the change and counts the stretch down on its own.
   int hold_seq = 0;
   int hold_len = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int cycle_count = 0;

   modbus_request_whitelist_filter_core u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_list_select    (req_list_select),
      .req_function_code  (req_function_code),
      .req_start_register (req_start_register),
      .req_register_count (req_register_count),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_verdict        (rsp_verdict),
      .rsp_status         (rsp_status),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Receiver side. Outside a hold-off, ready drops at random at the current idle rate.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_seen != hold_seq) begin
         hold_seen = hold_seq;
         hold_left = hold_len;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Everything that crosses the block's ports is observed here, at the clock edge, with
   // the values from before the edge. A request word is noted before a response word is
   // checked, though a response can never belong to a word taken at the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en) begin
            sb.set_active(csr_wr_data);
         end
         if (req_valid && req_ready) begin
            sb.note_request(req_kind, req_list_select, req_function_code,
                            req_start_register, req_register_count);
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_response(rsp_verdict, rsp_status);
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Offers one request word and returns at the edge where the block takes it. Any idle
   // cycles come first, so valid never drops while a word is on offer, and valid stays up
   // from one word to the next when no idle cycle falls between them.
   task send_word(input logic [1:0] kind, input logic sel, input logic [7:0] fc,
                  input logic [15:0] first, input logic [15:0] count);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_kind           <= kind;
      req_list_select    <= sel;
      req_function_code  <= fc;
      req_start_register <= first;
      req_register_count <= count;
      do begin
         @(posedge clock);
      end while (!req_ready);
   endtask

   // Stops offering words until every response word has come back. The first edge lets
   // the monitor note the last word taken before the count is looked at.
   task drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   // Only called with the block idle: nothing on offer and nothing pending.
   task write_active_list(input logic value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Rule fields: function codes mostly from a handful of values so that checks find them,
   // ranges near both ends of the register space, and counts of every flavor.
   task send_random_append();
      logic [7:0]  fc;
      logic [15:0] first;
      logic [15:0] count;
      int          pick;
      fc = ($urandom_range(99) < 70) ? 8'($urandom_range(1, 6)) : 8'($urandom_range(0, 255));
      pick = $urandom_range(2);
      if (pick == 0) begin
         first = 16'($urandom_range(0, 65535));
      end else if (pick == 1) begin
         first = 16'($urandom_range(0, 300));
      end else begin
         first = 16'hFFFF - 16'($urandom_range(0, 300));
      end
      pick = $urandom_range(99);
      if (pick < 15) begin
         count = 16'd0;
      end else if (pick < 65) begin
         count = 16'($urandom_range(1, 64));
      end else if (pick < 85) begin
         count = 16'($urandom_range(0, 65535));
      end else begin
         // Ranges that run past the top of the register space and wrap.
         count = 16'hFFFF - first + 16'($urandom_range(1, 40));
      end
      send_word(KIND_APPEND, 1'($urandom_range(1)), fc, first, count);
   endtask

   // A request aimed at one rule of the active list, landing inside it, at its edges or
   // just beyond, so that the range comparisons are really exercised.
   task send_aimed_check();
      rule_type    target;
      logic [7:0]  fc;
      logic [15:0] first;
      logic [15:0] count;
      int          idx;
      idx = $urandom_range(int'(sb.rule_total[sb.active]) - 1);
      target = sb.rules[sb.active][idx];
      fc = ($urandom_range(99) < 90) ? target.fc : 8'($urandom_range(0, 255));
      first = target.first + 16'($urandom_range(0, 24)) - 16'd3;
      if (target.count != 16'd0 && $urandom_range(99) < 30) begin
         // Exact fit up to the rule's last register, sometimes one past it.
         count = target.count - (first - target.first) + 16'($urandom_range(1));
      end else begin
         count = 16'($urandom_range(0, 24));
      end
      send_word(KIND_CHECK, 1'($urandom_range(1)), fc, first, count);
   endtask

   task send_random_word();
      int pick;
      pick = $urandom_range(99);
      if (pick < 45 && sb.rule_total[sb.active] != 0) begin
         send_aimed_check();
      end else if (pick < 60) begin
         send_word(KIND_CHECK, 1'($urandom_range(1)),
                   ($urandom_range(1) != 0) ? 8'($urandom_range(1, 6)) : 8'($urandom_range(0, 255)),
                   16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      end else if (pick < 88) begin
         send_random_append();
      end else if (pick < 96) begin
         send_word(KIND_CLEAR, 1'($urandom_range(1)), 8'($urandom_range(0, 255)),
                   16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      end else begin
         send_word(KIND_UNUSED, 1'($urandom_range(1)), 8'($urandom_range(0, 255)),
                   16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      end
   endtask

   initial begin
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, checks made against list 0 while list 1 is built up to full.
      write_active_list(1'b0);
      // A check against an empty list finds nothing.
      send_word(KIND_CHECK, 1'b0, 8'd3, 16'd0, 16'd1);
      // The unused kind with every field at its top value changes nothing.
      send_word(KIND_UNUSED, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF);
      send_word(KIND_CLEAR, 1'b1, 8'd0, 16'd0, 16'd0);
      send_word(KIND_APPEND, 1'b1, 8'd3, 16'd100, 16'd10);
      // A zero count lets the function code through at any register.
      send_word(KIND_APPEND, 1'b1, 8'd0, 16'd0, 16'd0);
      send_word(KIND_APPEND, 1'b1, 8'hFF, 16'hFFF0, 16'd16);
      // This rule's last register wraps round to 0.
      send_word(KIND_APPEND, 1'b1, 8'd16, 16'hFFFF, 16'd2);
      send_word(KIND_APPEND, 1'b1, 8'd6, 16'd0, 16'hFFFF);
      send_word(KIND_APPEND, 1'b1, 8'd1, 16'd500, 16'd1);
      for (int i = 6; i < MAX_RULES; i++) begin
         send_word(KIND_APPEND, 1'b1, 8'(i + 4), 16'(i * 1000), 16'd100);
      end
      // The list is full now, so this append is refused.
      send_word(KIND_APPEND, 1'b1, 8'd7, 16'd7, 16'd7);
      send_word(KIND_APPEND, 1'b0, 8'd3, 16'd0, 16'd5);
      send_word(KIND_CHECK, 1'b1, 8'd3, 16'd2, 16'd3);
      drain();

      // Directed checks against the full list.
      write_active_list(1'b1);
      send_word(KIND_CHECK, 1'b0, 8'd3, 16'd100, 16'd10);
      send_word(KIND_CHECK, 1'b0, 8'd3, 16'd99, 16'd2);
      send_word(KIND_CHECK, 1'b0, 8'd0, 16'hFFFF, 16'hFFFF);
      send_word(KIND_CHECK, 1'b0, 8'hFF, 16'hFFF0, 16'd16);
      // A zero request count wraps the request's last register to one below its start.
      send_word(KIND_CHECK, 1'b0, 8'd1, 16'd500, 16'd0);
      send_word(KIND_CHECK, 1'b0, 8'd16, 16'hFFFF, 16'd1);
      send_word(KIND_CHECK, 1'b0, 8'd6, 16'd0, 16'hFFFF);
      drain();

      // Random part. The first third idles mostly on the receiver side, the second mostly
      // on the sender side, and the last runs flat out.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase < RANDOM_PHASES / 3) begin
            tx_idle_pct = 30;
            rx_idle_pct = 55;
         end else if (phase < 2 * RANDOM_PHASES / 3) begin
            tx_idle_pct = 55;
            rx_idle_pct = 30;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         write_active_list(1'($urandom_range(1)));
         if (phase == 2 * RANDOM_PHASES / 3) begin
            // Back pressure: the receiver shuts off while words keep coming, so the
            // response register and the sequencer both fill and input ready drops.
            hold_len = 300;
            hold_seq = hold_seq + 1;
         end
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            if (phase == RANDOM_PHASES / 2 && n == WORDS_PER_PHASE / 2) begin
               drain();
            end
            send_random_word();
         end
         drain();
      end

      // All words are back; give a late stray response time to show up.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.pending() != 0) begin
         sb.report($sformatf("%0d response words never arrived", sb.pending()));
      end
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/mbwl_pkg.sv
rtl/core/mbwl_rule_ram.sv
rtl/core/mbwl_match_unit.sv
rtl/core/modbus_request_whitelist_filter_core.sv
tb/modbus_request_whitelist_filter_core_test.sv
